// File: design/abdl_pkg.sv
// Package: shared constants, types and a helper function of the delta lister.
`timescale 1ns / 1ps

package abdl_pkg;

	localparam int MAX_POSITIONS = 4096;
	localparam int WORD_BITS     = 32;
	localparam int BIT_W         = $clog2(WORD_BITS);
	localparam int POS_W         = $clog2(MAX_POSITIONS);
	localparam int WIDX_W        = POS_W - BIT_W;
	localparam int CNT_W         = 13;
	localparam int DELTA_W       = 8;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 13;
	localparam int QUEUE_DEPTH   = 2;
	localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

	localparam logic [DELTA_W-1:0] BRIDGE_DELTA = 8'd255;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_NUM_SENONES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ALL_ACTIVE  = 1'b1;

	// One classified word, handed from the front end to the back end
	typedef struct packed {
		logic [WORD_BITS-1:0] flags;       // bitmap word, bits past the frame cleared
		logic [WIDX_W-1:0]    word_index;  // word position within the frame
		logic                 final_word;  // word closes the frame
		logic                 all_active;  // emit the all-active summary only
		logic [CNT_W-1:0]     positions;   // clamped frame size
	} abdl_item_t;

	typedef enum logic {
		BK_IDLE,
		BK_SCAN
	} back_state_t;

	// Index of the lowest set bit; zero for an empty word
	function automatic logic [BIT_W-1:0] lowest_index(input logic [WORD_BITS-1:0] w);
		logic [WORD_BITS-1:0] iso;
		logic [BIT_W-1:0]     idx;
		iso = w & (~w + WORD_BITS'(1));
		idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (iso[i]) begin
				idx = idx | BIT_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

// File: design/abdl_if.sv
// Interfaces: bitmap word channel and result channel.
`timescale 1ns / 1ps

interface abdl_word_if;
	logic                           valid;
	logic                           ready;
	logic [abdl_pkg::WORD_BITS-1:0] flag_word;

	modport source (output valid, output flag_word, input ready);
	modport sink   (input valid, input flag_word, output ready);
endinterface

interface abdl_result_if;
	logic                         valid;
	logic                         ready;
	logic [abdl_pkg::DELTA_W-1:0] delta;
	logic                         is_entry;
	logic [abdl_pkg::CNT_W-1:0]   active_count;
	logic                         last;

	modport source (output valid, output delta, output is_entry, output active_count,
		output last, input ready);
	modport sink   (input valid, input delta, input is_entry, input active_count,
		input last, output ready);
endinterface

// File: design/abdl_front.sv
// Front end: configuration registers, word tracking and masking of incoming words.
`timescale 1ns / 1ps

module abdl_front (
	input  logic                              clk,
	input  logic                              arst_n,
	abdl_word_if.sink                         words,
	input  logic                              cfg_we,
	input  logic [abdl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [abdl_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                              push_valid,
	input  logic                              push_ready,
	output abdl_pkg::abdl_item_t              push_item
);

	logic [abdl_pkg::CNT_W-1:0]     num_senones_q;
	logic                           all_active_q;
	logic [abdl_pkg::WIDX_W-1:0]    word_index_q;

	logic [abdl_pkg::CNT_W-1:0]     eff_n;
	logic [abdl_pkg::CNT_W-1:0]     word_count;
	logic [abdl_pkg::CNT_W-1:0]     base_pos;
	logic [abdl_pkg::CNT_W-1:0]     remain;
	logic [abdl_pkg::WORD_BITS-1:0] keep_mask;
	logic                           final_word;
	logic                           push;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_senones_q <= abdl_pkg::CNT_W'(abdl_pkg::MAX_POSITIONS);
			all_active_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				abdl_pkg::REG_NUM_SENONES: num_senones_q <= cfg_data;
				abdl_pkg::REG_ALL_ACTIVE:  all_active_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clamp the frame size and find the final word
	always_comb begin
		if (num_senones_q == '0) begin
			eff_n = abdl_pkg::CNT_W'(1);
		end else if (num_senones_q > abdl_pkg::CNT_W'(abdl_pkg::MAX_POSITIONS)) begin
			eff_n = abdl_pkg::CNT_W'(abdl_pkg::MAX_POSITIONS);
		end else begin
			eff_n = num_senones_q;
		end
		word_count = (eff_n + abdl_pkg::CNT_W'(abdl_pkg::WORD_BITS - 1)) >> abdl_pkg::BIT_W;
		final_word = (abdl_pkg::CNT_W'(word_index_q) + abdl_pkg::CNT_W'(1)) >= word_count;
	end

	// Mask off bits past the end of the frame
	always_comb begin
		base_pos = abdl_pkg::CNT_W'({word_index_q, abdl_pkg::BIT_W'(0)});
		remain   = eff_n - base_pos;
		if (eff_n <= base_pos) begin
			keep_mask = '0;
		end else if (remain >= abdl_pkg::CNT_W'(abdl_pkg::WORD_BITS)) begin
			keep_mask = '1;
		end else begin
			keep_mask = (abdl_pkg::WORD_BITS'(1) << remain[abdl_pkg::BIT_W-1:0])
				- abdl_pkg::WORD_BITS'(1);
		end
	end

	// Hand the classified word to the queue
	assign words.ready = push_ready;
	assign push_valid  = words.valid;
	assign push        = words.valid && push_ready;

	always_comb begin
		push_item.flags      = words.flag_word & keep_mask;
		push_item.word_index = word_index_q;
		push_item.final_word = final_word;
		push_item.all_active = all_active_q;
		push_item.positions  = eff_n;
	end

	// Advance the word position, rearm at the end of a frame or on every word in all_active mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_index_q <= '0;
		end else if (push) begin
			if (all_active_q || final_word) begin
				word_index_q <= '0;
			end else begin
				word_index_q <= word_index_q + abdl_pkg::WIDX_W'(1);
			end
		end
	end

endmodule

// File: design/abdl_queue.sv
// Two-entry queue of classified words between front end and back end.
`timescale 1ns / 1ps

module abdl_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  abdl_pkg::abdl_item_t push_item,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output abdl_pkg::abdl_item_t pop_item
);

	abdl_pkg::abdl_item_t               slots_q [abdl_pkg::QUEUE_DEPTH];
	logic [abdl_pkg::QUEUE_PTR_W-1:0]   wr_ptr_q;
	logic [abdl_pkg::QUEUE_PTR_W-1:0]   rd_ptr_q;
	logic [abdl_pkg::QUEUE_CNT_W-1:0]   fill_q;
	logic                               push;
	logic                               pop;

	assign push_ready = fill_q != abdl_pkg::QUEUE_CNT_W'(abdl_pkg::QUEUE_DEPTH);
	assign pop_valid  = fill_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = slots_q[rd_ptr_q];

	// Store incoming items
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + abdl_pkg::QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + abdl_pkg::QUEUE_PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + abdl_pkg::QUEUE_CNT_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - abdl_pkg::QUEUE_CNT_W'(1);
			end
		end
	end

endmodule

// File: design/abdl_back.sv
// Back end: walks the set bits of each word and emits deltas, bridges and summaries.
`timescale 1ns / 1ps

module abdl_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  abdl_pkg::abdl_item_t pop_item,
	abdl_result_if.source        results
);

	abdl_pkg::back_state_t          state_q;
	abdl_pkg::back_state_t          state_d;

	logic [abdl_pkg::WORD_BITS-1:0] word_q;
	logic [abdl_pkg::WIDX_W-1:0]    widx_q;
	logic                           final_q;
	logic                           allact_q;
	logic [abdl_pkg::CNT_W-1:0]     positions_q;
	logic [abdl_pkg::POS_W-1:0]     prev_q;
	logic [abdl_pkg::CNT_W-1:0]     count_q;

	logic                           out_valid_q;
	logic [abdl_pkg::DELTA_W-1:0]   out_delta_q;
	logic                           out_entry_q;
	logic [abdl_pkg::CNT_W-1:0]     out_count_q;
	logic                           out_last_q;

	logic [abdl_pkg::BIT_W-1:0]     bit_idx;
	logic [abdl_pkg::POS_W-1:0]     pos;
	logic [abdl_pkg::POS_W:0]       gap_len;
	logic [abdl_pkg::WORD_BITS-1:0] word_rest;
	logic                           step_ok;

	logic                           load;
	logic                           emit;
	logic [abdl_pkg::DELTA_W-1:0]   emit_delta;
	logic                           emit_entry;
	logic [abdl_pkg::CNT_W-1:0]     emit_count;
	logic                           emit_last;
	logic                           bridge;
	logic                           take_bit;
	logic                           rearm;
	logic                           done;

	// Locate the next active position and its distance
	always_comb begin
		bit_idx   = abdl_pkg::lowest_index(word_q);
		pos       = {widx_q, bit_idx};
		gap_len   = {1'b0, pos} - {1'b0, prev_q};
		word_rest = word_q & (word_q - abdl_pkg::WORD_BITS'(1));
	end

	assign step_ok = !out_valid_q || results.ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			abdl_pkg::BK_IDLE: begin
				if (pop_valid) begin
					state_d = abdl_pkg::BK_SCAN;
				end
			end
			abdl_pkg::BK_SCAN: begin
				if (done) begin
					state_d = abdl_pkg::BK_IDLE;
				end
			end
			default: state_d = abdl_pkg::BK_IDLE;
		endcase
	end

	// Per-cycle actions
	always_comb begin
		load       = 1'b0;
		emit       = 1'b0;
		emit_delta = '0;
		emit_entry = 1'b0;
		emit_count = '0;
		emit_last  = 1'b0;
		bridge     = 1'b0;
		take_bit   = 1'b0;
		rearm      = 1'b0;
		done       = 1'b0;
		case (state_q)
			abdl_pkg::BK_IDLE: begin
				load = pop_valid;
			end
			abdl_pkg::BK_SCAN: begin
				if (step_ok) begin
					if (allact_q) begin
						emit       = 1'b1;
						emit_count = positions_q;
						emit_last  = 1'b1;
						rearm      = 1'b1;
						done       = 1'b1;
					end else if (word_q != '0) begin
						emit       = 1'b1;
						emit_entry = 1'b1;
						if (gap_len > (abdl_pkg::POS_W + 1)'(abdl_pkg::BRIDGE_DELTA)) begin
							emit_delta = abdl_pkg::BRIDGE_DELTA;
							bridge     = 1'b1;
						end else begin
							emit_delta = gap_len[abdl_pkg::DELTA_W-1:0];
							take_bit   = 1'b1;
							emit_last  = (word_rest == '0) && !final_q;
						end
					end else if (final_q) begin
						emit       = 1'b1;
						emit_count = count_q;
						emit_last  = 1'b1;
						rearm      = 1'b1;
						done       = 1'b1;
					end else begin
						done = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	assign pop_ready = load;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= abdl_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the word under scan
	always_ff @(posedge clk) begin
		if (load) begin
			word_q      <= pop_item.flags;
			widx_q      <= pop_item.word_index;
			final_q     <= pop_item.final_word;
			allact_q    <= pop_item.all_active;
			positions_q <= pop_item.positions;
		end else if (take_bit) begin
			word_q <= word_rest;
		end
	end

	// Track previous position and entry count of the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			count_q <= '0;
		end else if (rearm) begin
			prev_q  <= '0;
			count_q <= '0;
		end else if (emit) begin
			count_q <= count_q + abdl_pkg::CNT_W'(1);
			if (bridge) begin
				prev_q <= prev_q + abdl_pkg::POS_W'(abdl_pkg::BRIDGE_DELTA);
			end else if (take_bit) begin
				prev_q <= pos;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_ok) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step_ok && emit) begin
			out_delta_q <= emit_delta;
			out_entry_q <= emit_entry;
			out_count_q <= emit_count;
			out_last_q  <= emit_last;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.delta        = out_delta_q;
	assign results.is_entry     = out_entry_q;
	assign results.active_count = out_count_q;
	assign results.last         = out_last_q;

`ifndef NO_ASSERTIONS
	// Positions within a frame never go backward
	a_no_backward: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == abdl_pkg::BK_SCAN && !allact_q && word_q != '0) |-> (pos >= prev_q))
		else $error("next position lies before the previous one");

	// A summary always closes its word
	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.is_entry) |-> (results.last && results.delta == '0))
		else $error("summary item without last or with nonzero delta");

	// List entries carry no count
	a_entry_count: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.is_entry) |-> (results.active_count == '0))
		else $error("list entry carries a count");

	// A bridge entry is never the last result of a word
	a_bridge_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(step_ok && bridge) |=> (out_valid_q && !out_last_q))
		else $error("bridge entry marked last");
`endif

endmodule

// File: design/active_bitmap_delta_lister.sv
// Top level: bitmap-to-delta lister with front end, word queue and back end.
//
// Each accepted 32-bit bitmap word is masked against num_senones and placed in a
// two-deep queue, so words keep flowing in while results drain. The back end loads a
// word from the queue and then emits each list and bridge entry that the word yields
// in turn (the lowest set bit is found combinationally); a closing step emits the
// frame summary on the final word or retires a word that has nothing more to emit.
// It finishes one word before it loads the next. A word in all_active mode emits
// only the summary. Stalls on the result channel hold the back end.
`timescale 1ns / 1ps

module active_bitmap_delta_lister (
	input  logic                            clk,
	input  logic                            arst_n,
	abdl_word_if.sink                       words,
	abdl_result_if.source                   results,
	input  logic                            cfg_we,
	input  logic [abdl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [abdl_pkg::CFG_DATA_W-1:0] cfg_data
);

	abdl_pkg::abdl_item_t push_item;
	abdl_pkg::abdl_item_t pop_item;
	logic                 push_valid;
	logic                 push_ready;
	logic                 pop_valid;
	logic                 pop_ready;

	abdl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.words      (words),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	abdl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	abdl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.results   (results)
	);

endmodule

// File: tb/sv/active_bitmap_delta_lister_tb.sv
// Testbench of the bitmap-to-delta lister: directed and random frames checked against a predictor.
`timescale 1ns / 1ps

module active_bitmap_delta_lister_tb;

	typedef struct packed {
		logic [abdl_pkg::DELTA_W-1:0] delta;
		logic                         is_entry;
		logic [abdl_pkg::CNT_W-1:0]   active_count;
		logic                         last;
	} delta_result_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [abdl_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [abdl_pkg::CFG_DATA_W-1:0] cfg_data;

	abdl_word_if   word_ch();
	abdl_result_if result_ch();

	// Words waiting to be sent and results still owed by the block
	logic [abdl_pkg::WORD_BITS-1:0] word_backlog[$];
	delta_result_t                  expected_deltas[$];
	delta_result_t                  oldest_delta;

	// Mirror of the registers and of the frame walk
	int cfg_senones    = abdl_pkg::MAX_POSITIONS;
	bit cfg_all_on     = 1'b0;
	int frame_prev_pos = 0;
	int frame_word_idx = 0;
	int frame_entries  = 0;

	int src_idle_pct;
	int snk_idle_pct;
	int random_fed = 0;
	int mismatches = 0;

	active_bitmap_delta_lister i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.words     (word_ch),
		.results   (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int clamp_positions(input int n);
		if (n == 0) begin
			return 1;
		end
		return (n > abdl_pkg::MAX_POSITIONS) ? abdl_pkg::MAX_POSITIONS : n;
	endfunction

	function automatic void push_result(input int delta, input bit is_entry, input int count);
		delta_result_t r;
		r.delta        = abdl_pkg::DELTA_W'(delta);
		r.is_entry     = is_entry;
		r.active_count = abdl_pkg::CNT_W'(count);
		r.last         = 1'b0;
		expected_deltas.push_back(r);
	endfunction

	// Walk one bitmap word and queue the deltas, bridges and summary it causes
	function automatic void predict_deltas(input logic [abdl_pkg::WORD_BITS-1:0] word);
		int            n;
		int            words_in_frame;
		int            pos;
		int            gap;
		int            produced;
		bit            closes_frame;
		delta_result_t r;
		n = clamp_positions(cfg_senones);
		produced = 0;
		if (cfg_all_on) begin
			push_result(0, 1'b0, n);
			produced = 1;
			frame_prev_pos = 0;
			frame_word_idx = 0;
			frame_entries  = 0;
		end else begin
			words_in_frame = (n + abdl_pkg::WORD_BITS - 1) / abdl_pkg::WORD_BITS;
			closes_frame   = (frame_word_idx + 1 >= words_in_frame);
			for (int b = 0; b < abdl_pkg::WORD_BITS; b++) begin
				if (word[b]) begin
					pos = frame_word_idx * abdl_pkg::WORD_BITS + b;
					if (pos >= n) begin
						break;
					end
					gap = pos - frame_prev_pos;
					while (gap > int'(abdl_pkg::BRIDGE_DELTA)) begin
						push_result(int'(abdl_pkg::BRIDGE_DELTA), 1'b1, 0);
						produced++;
						frame_entries++;
						gap -= int'(abdl_pkg::BRIDGE_DELTA);
					end
					push_result(gap, 1'b1, 0);
					produced++;
					frame_entries++;
					frame_prev_pos = pos;
				end
			end
			if (closes_frame) begin
				push_result(0, 1'b0, frame_entries);
				produced++;
				frame_prev_pos = 0;
				frame_word_idx = 0;
				frame_entries  = 0;
			end else begin
				frame_word_idx++;
			end
		end
		// Flag the final result of this word
		if (produced > 0) begin
			r = expected_deltas.pop_back();
			r.last = 1'b1;
			expected_deltas.push_back(r);
		end
	endfunction

	// Word driver: predict on each transfer, then offer the next word or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_ch.valid <= 1'b0;
		end else begin
			if (word_ch.valid && word_ch.ready) begin
				predict_deltas(word_ch.flag_word);
			end
			if (!word_ch.valid || word_ch.ready) begin
				if (word_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					word_ch.valid     <= 1'b1;
					word_ch.flag_word <= word_backlog.pop_front();
				end else begin
					word_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each transfer with the oldest expectation, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_deltas.size() == 0) begin
					$error("unexpected result: delta %0d is_entry %0d active_count %0d last %0d",
						result_ch.delta, result_ch.is_entry, result_ch.active_count,
						result_ch.last);
					mismatches++;
				end else begin
					oldest_delta = expected_deltas.pop_front();
					if (result_ch.delta !== oldest_delta.delta) begin
						$error("delta: expected %0d, actual %0d",
							oldest_delta.delta, result_ch.delta);
						mismatches++;
					end
					if (result_ch.is_entry !== oldest_delta.is_entry) begin
						$error("is_entry: expected %0d, actual %0d",
							oldest_delta.is_entry, result_ch.is_entry);
						mismatches++;
					end
					if (result_ch.active_count !== oldest_delta.active_count) begin
						$error("active_count: expected %0d, actual %0d",
							oldest_delta.active_count, result_ch.active_count);
						mismatches++;
					end
					if (result_ch.last !== oldest_delta.last) begin
						$error("last: expected %0d, actual %0d",
							oldest_delta.last, result_ch.last);
						mismatches++;
					end
				end
			end
			result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Hold until every word is sent and every result seen, then let the back end retire
	task automatic wait_idle();
		while (word_backlog.size() != 0 || word_ch.valid || expected_deltas.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [abdl_pkg::CFG_IDX_W-1:0] idx, input int value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= abdl_pkg::CFG_DATA_W'(value);
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic apply_config(input int n, input bit all_on);
		wait_idle();
		write_reg(abdl_pkg::REG_NUM_SENONES, n);
		write_reg(abdl_pkg::REG_ALL_ACTIVE, int'(all_on));
		cfg_senones = n;
		cfg_all_on  = all_on;
	endtask

	// One random setting followed by random words: whole frames, now and then left open, or part of a frame over 40 words
	task automatic random_phase();
		int                             pick;
		int                             n;
		int                             frame_words;
		int                             count;
		int                             style;
		bit                             all_on;
		logic [abdl_pkg::WORD_BITS-1:0] w;
		pick = $urandom_range(15);
		if (pick < 9) begin
			n = $urandom_range(1, 160);
		end else if (pick < 13) begin
			n = $urandom_range(161, 1200);
		end else if (pick == 13) begin
			n = $urandom_range(1201, abdl_pkg::MAX_POSITIONS);
		end else if (pick == 14) begin
			n = $urandom_range(abdl_pkg::MAX_POSITIONS + 1, 8191);
		end else begin
			n = 0;
		end
		all_on = ($urandom_range(7) == 0);
		frame_words = (clamp_positions(n) + abdl_pkg::WORD_BITS - 1) / abdl_pkg::WORD_BITS;
		if (all_on) begin
			count = $urandom_range(1, 4);
		end else if (frame_words > 40) begin
			count = $urandom_range(3, 12);
		end else begin
			count = (frame_words > 5) ? frame_words : frame_words * $urandom_range(1, 3);
			if ($urandom_range(5) == 0) begin
				count += $urandom_range(1, 3);
			end
		end
		apply_config(n, all_on);
		style = $urandom_range(3);
		for (int i = 0; i < count; i++) begin
			case (style)
				0: begin
					w = $urandom;
				end
				1: begin
					w = $urandom & $urandom & $urandom & $urandom;
				end
				2: begin
					w = ($urandom_range(7) == 0) ? (32'h1 << $urandom_range(31)) : '0;
				end
				default: begin
					w = $urandom | $urandom;
				end
			endcase
			word_backlog.push_back(w);
			random_fed++;
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = '0;
		cfg_data          = '0;
		word_ch.valid     = 1'b0;
		word_ch.flag_word = '0;
		result_ch.ready   = 1'b0;
		src_idle_pct      = 26;
		snk_idle_pct      = 56;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Two-word frames: position 0, bits past the frame, empty words, frame edges
		apply_config(40, 1'b0);
		word_backlog.push_back(32'h0000_0001);
		word_backlog.push_back(32'hFFFF_FFFF);
		word_backlog.push_back(32'h0000_0000);
		word_backlog.push_back(32'h0000_0000);
		word_backlog.push_back(32'h8000_0000);
		word_backlog.push_back(32'h0000_0080);

		// Gap over 255 bridged at the very end of the frame
		apply_config(288, 1'b0);
		for (int i = 0; i < 8; i++) begin
			word_backlog.push_back(32'h0000_0000);
		end
		word_backlog.push_back(32'h8000_0000);

		// Shrink the frame mid-way so the next word closes it
		apply_config(abdl_pkg::MAX_POSITIONS, 1'b0);
		word_backlog.push_back(32'h0000_0003);
		word_backlog.push_back(32'h0000_0000);
		word_backlog.push_back(32'hFFFF_0000);
		apply_config(64, 1'b0);
		word_backlog.push_back(32'hFFFF_FFFF);

		// Out-of-range sizes, with and without all positions active
		apply_config(8191, 1'b1);
		word_backlog.push_back(32'h0000_0000);
		apply_config(0, 1'b1);
		word_backlog.push_back(32'h1234_5678);
		apply_config(0, 1'b0);
		word_backlog.push_back(32'hFFFF_FFFF);

		// Random part over three idling eras
		for (int era = 0; era < 3; era++) begin
			case (era)
				0: begin
					src_idle_pct = 26;
					snk_idle_pct = 56;
				end
				1: begin
					src_idle_pct = 56;
					snk_idle_pct = 26;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			while (random_fed < (era + 1) * 64) begin
				random_phase();
			end
		end

		wait_idle();
		if (mismatches == 0) begin
			$display("active_bitmap_delta_lister: match");
		end else begin
			$display("active_bitmap_delta_lister: mismatch");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#5_000_000;
		$display("active_bitmap_delta_lister: mismatch");
		$finish;
	end

endmodule

// File: files.f
design/abdl_pkg.sv
design/abdl_if.sv
design/abdl_front.sv
design/abdl_queue.sv
design/abdl_back.sv
design/active_bitmap_delta_lister.sv
tb/sv/active_bitmap_delta_lister_tb.sv
